// File: hw/rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CAP_BITS       = 5;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_value;
        logic [15:0]        use_count;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_out_item;
endpackage

// File: hw/rtl/lfu_cache_table.sv
// Top level of the LFU cache table: input queue, engine, config register.
`timescale 1ns / 1ps
// Usage:
//  Input side is a queue: drive push with full low to enter an item
//  (get, set or clear with key and value). Results come out in order:
//  while empty is low the oldest result sits on o_result; pop takes it.
//  One result per item. The capacity register is written through
//  i_cfg_valid / o_cfg_ready; ready is high only while the block is idle.
//  Get and set scan every table entry (one table entry is
//  examined per cycle in the engine's scan); a set that evicts adds
//  a rank update sweep over all entries; clear skips the scan.
//  The engine takes a new item only after the result of the last one
//  has been popped, so items are handled one at a time.
//  A two-deep input queue keeps accepting while the engine works, and the
//  engine holds one finished result; when the receiver stalls, the engine
//  stops after filling its result slot and the input queue then fills.
//  Reset empties the table, the queue and the result slot and sets the
//  capacity to 16.
module lfu_cache_table #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  lfu_pkg::t_in_item            i_item,
    output logic                         empty,
    input  logic                         pop,
    output lfu_pkg::t_out_item           o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0] i_cfg_data
);
    logic [lfu_pkg::CAP_BITS-1:0] r_cap;
    logic q_valid, take, busy;
    lfu_pkg::t_in_item q_item;

    // capacity changes only with nothing in flight
    assign o_cfg_ready = !busy && !q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= lfu_pkg::CAP_BITS'(16);
        else if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
    end

    lfu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_item(i_item),
        .o_full(full), .o_valid(q_valid), .o_item(q_item), .i_take(take)
    );

    lfu_engine #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cap(r_cap), .i_valid(q_valid),
        .i_item(q_item), .o_take(take), .o_busy(busy), .o_empty(empty),
        .o_result(o_result), .i_pop(pop)
    );
endmodule

// File: hw/rtl/lfu_front.sv
// Front end: input queue that accepts and holds items for the engine.
`timescale 1ns / 1ps
module lfu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lfu_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_valid,
    output lfu_pkg::t_in_item o_item,
    input  logic              i_take
);
    lfu_pkg::t_in_item r_buf [lfu_pkg::QUEUE_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == 2'(lfu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

// File: hw/rtl/lfu_engine.sv
// Back end: scans entries one per cycle, updates the table, and holds the result.
`timescale 1ns / 1ps
module lfu_engine #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lfu_pkg::CAP_BITS-1:0]  i_cap,
    input  logic                          i_valid,
    input  lfu_pkg::t_in_item             i_item,
    output logic                          o_take,
    output logic                          o_busy,
    output logic                          o_empty,
    output lfu_pkg::t_out_item            o_result,
    input  logic                          i_pop
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_RANK, S_OUT} t_state;
    t_state r_state;

    logic                  r_vld  [ENTRIES];
    logic [31:0]           r_key  [ENTRIES];
    logic [31:0]           r_val  [ENTRIES];
    logic [COUNT_BITS-1:0] r_cnt  [ENTRIES];
    logic [IW-1:0]         r_rank [ENTRIES];
    logic [OW-1:0]         r_occ;

    lfu_pkg::t_in_item r_cur;
    logic [IW:0]   r_i;
    logic          r_found, r_have_vic, r_have_free;
    logic [IW-1:0] r_slot, r_vic, r_free, r_vrank;
    lfu_pkg::t_out_item r_res;
    logic          r_full_q;
    logic [OW-1:0] cap_eff;
    logic [IW-1:0] idx;
    logic [COUNT_BITS-1:0] bumped;
    logic [15:0]   bump16;

    assign idx     = r_i[IW-1:0];
    assign cap_eff = (32'(i_cap) > ENTRIES) ? OW'(ENTRIES) : OW'(i_cap);
    assign bumped  = (r_cnt[r_slot] == CMAX) ? CMAX : r_cnt[r_slot] + 1'b1;
    assign bump16  = 16'(32'(bumped));
    assign o_take  = (r_state == S_IDLE) && !r_full_q;
    assign o_busy  = (r_state != S_IDLE) || r_full_q;
    assign o_empty = !r_full_q;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_full_q <= 1'b0;
            r_occ    <= '0;
            for (int j = 0; j < ENTRIES; j++) r_vld[j] <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // the result slot is only ever full while idle
                    if (r_full_q) begin
                        if (i_pop) r_full_q <= 1'b0;
                    end else if (i_valid) begin
                        r_cur       <= i_item;
                        r_i         <= '0;
                        r_found     <= 1'b0;
                        r_have_vic  <= 1'b0;
                        r_have_free <= 1'b0;
                        r_res       <= '0;
                        if (i_item.cmd == lfu_pkg::CMD_CLEAR) begin
                            for (int j = 0; j < ENTRIES; j++) r_vld[j] <= 1'b0;
                            r_occ   <= '0;
                            r_state <= S_OUT;
                        end else if (i_item.cmd == lfu_pkg::CMD_GET ||
                                     i_item.cmd == lfu_pkg::CMD_SET) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    // one entry per cycle: key match, first free, LFU victim
                    if (r_vld[idx]) begin
                        if (!r_found && r_key[idx] == r_cur.key) begin
                            r_found <= 1'b1;
                            r_slot  <= idx;
                        end
                        if (!r_have_vic || r_cnt[idx] < r_cnt[r_vic] ||
                            (r_cnt[idx] == r_cnt[r_vic] && r_rank[idx] < r_vrank)) begin
                            r_have_vic <= 1'b1;
                            r_vic      <= idx;
                            r_vrank    <= r_rank[idx];
                        end
                    end else if (!r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free      <= idx;
                    end
                    if (32'(r_i) == ENTRIES - 1) r_state <= S_ACT;
                    r_i <= r_i + 1'b1;
                end
                S_ACT: begin
                    r_state <= S_OUT;
                    if (r_found) begin
                        r_res.hit       <= 1'b1;
                        if (r_cur.cmd == lfu_pkg::CMD_GET) begin
                            r_cnt[r_slot]    <= bumped;
                            r_res.read_value <= r_val[r_slot];
                            r_res.use_count  <= bump16;
                        end else if (cap_eff == '0) begin
                            r_res.use_count <= 16'(32'(r_cnt[r_slot]));
                        end else begin
                            r_cnt[r_slot]   <= bumped;
                            r_val[r_slot]   <= r_cur.value;
                            r_res.use_count <= bump16;
                        end
                    end else if (r_cur.cmd == lfu_pkg::CMD_SET && cap_eff != '0) begin
                        if (r_occ >= cap_eff && r_have_vic) begin
                            // evict, then close the gap in insertion ranks
                            r_res.evicted     <= 1'b1;
                            r_res.evicted_key <= r_key[r_vic];
                            r_vld[r_vic]      <= 1'b0;
                            r_occ             <= r_occ - 1'b1;
                            r_i               <= '0;
                            r_state           <= S_RANK;
                        end else if (r_have_free) begin
                            r_vld[r_free]   <= 1'b1;
                            r_key[r_free]   <= r_cur.key;
                            r_val[r_free]   <= r_cur.value;
                            r_cnt[r_free]   <= COUNT_BITS'(1);
                            r_rank[r_free]  <= IW'(r_occ);
                            r_occ           <= r_occ + 1'b1;
                            r_res.use_count <= 16'd1;
                        end
                    end
                end
                S_RANK: begin
                    if (r_vld[idx] && r_rank[idx] > r_vrank)
                        r_rank[idx] <= r_rank[idx] - 1'b1;
                    r_i <= r_i + 1'b1;
                    if (32'(r_i) == ENTRIES - 1) begin
                        // the victim's slot is free now; lowest free is min(free, vic)
                        r_free      <= (r_have_free && r_free < r_vic) ? r_free : r_vic;
                        r_have_free <= 1'b1;
                        r_have_vic  <= 1'b0;
                        r_state     <= S_ACT;
                    end
                end
                S_OUT: begin
                    r_full_q <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/lfu_checker.sv
// Port-level assertions for the LFU cache table, bound to the top level.
`timescale 1ns / 1ps
module lfu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input lfu_pkg::t_out_item o_result
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while waiting");
    a_evk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.evicted) |-> (o_result.evicted_key == 32'sd0))
        else $error("evicted key without eviction");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.hit) |-> (o_result.read_value == 32'sd0))
        else $error("read value on miss");
    a_ev_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.evicted) |-> (o_result.use_count == 16'd1 && !o_result.hit))
        else $error("eviction must insert new entry");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("not empty after reset");
endmodule

bind lfu_cache_table lfu_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .full(full),
    .empty(empty), .pop(pop), .o_result(o_result)
);
